// File: src/twdc_pkg.sv
// ----------------------------------------------------------------------------
// twdc_pkg: shared types and constants of the tilt window classifier
// Field widths, register indexes, reset values, the direction codes and the settings struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twdc_pkg;

  // field widths
  localparam int unsigned SMP_W      = 8;   // raw sample
  localparam int unsigned AVG_W      = 12;  // Q4 average, also quotient bits
  localparam int unsigned THR_W      = 11;  // thresholds
  localparam int unsigned TICK_W     = 16;  // elapsed ticks and window
  localparam int unsigned EV_W       = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned Q4_SHIFT   = 4;

  localparam int unsigned DEF_MAX_SAMPLES = 1024;

  // register reset values
  localparam logic [THR_W-1:0]         RST_CHANGE_THR  = THR_W'(192);
  localparam logic [THR_W-1:0]         RST_RELEASE_THR = THR_W'(96);
  localparam logic signed [AVG_W-1:0]  RST_Y_OFFSET    = AVG_W'(72);
  localparam logic [TICK_W-1:0]        RST_WINDOW      = TICK_W'(100);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANGE_THR  = 2'd0,
    CFG_RELEASE_THR = 2'd1,
    CFG_Y_OFFSET    = 2'd2,
    CFG_WINDOW      = 2'd3
  } cfg_idx_e;

  // direction codes
  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4
  } ev_e;

  // classifier settings
  typedef struct packed {
    logic [THR_W-1:0]        change_thr;
    logic [THR_W-1:0]        release_thr;
    logic signed [AVG_W-1:0] y_offset;
  } cls_cfg_t;

endpackage : twdc_pkg

`default_nettype wire

// File: src/tilt_window_direction_classifier_core.sv
// Timing: a tick, or a sample that leaves the window open, leaves the core in ST_IDLE.
// A closing sample runs ST_X_GO, ST_X_WAIT, ST_Y_GO, ST_Y_WAIT and ST_LOAD: two
// passes of the shared serial divider plus sequencing, longer while a result
// still waits at the output. No new input is accepted until ST_LOAD has passed.
// Reset (rst_ni low, async) clears the window, the event, the output register
// and loads the register defaults.
// ----------------------------------------------------------------------------
// tilt_window_direction_classifier_core: top level
// Accumulates tilt samples over a tick window, divides the sums by the
// sample count into Q4 averages and classifies the tilt direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tilt_window_direction_classifier_core #(
  parameter int unsigned MAX_SAMPLES = twdc_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [twdc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // sample_x, sample_y
  input  wire logic [0:0]                           s_axis_tuser,  // action
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [twdc_pkg::OUT_DATA_W-1:0]           m_axis_tdata,  // event, avg_x, avg_y
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [twdc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [twdc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import twdc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = CNT_W + SMP_W;
  localparam int unsigned PAD_W = OUT_DATA_W - EV_W - 2 * AVG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_LOAD
  } state_e;

  // configuration registers
  cls_cfg_t          cfg_q;
  logic [TICK_W-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.change_thr  <= RST_CHANGE_THR;
      cfg_q.release_thr <= RST_RELEASE_THR;
      cfg_q.y_offset    <= RST_Y_OFFSET;
      window_q          <= RST_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANGE_THR:  cfg_q.change_thr  <= cfg_data_i[THR_W-1:0];
        CFG_RELEASE_THR: cfg_q.release_thr <= cfg_data_i[THR_W-1:0];
        CFG_Y_OFFSET:    cfg_q.y_offset    <= cfg_data_i[AVG_W-1:0];
        CFG_WINDOW:      window_q          <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  state_e                  state_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [TICK_W-1:0]       ticks_q;
  ev_e                     ev_q;
  logic [AVG_W-1:0]        qx_q;
  logic                    out_valid_q;
  ev_e                     out_ev_q;
  logic signed [AVG_W-1:0] out_x_q, out_y_q;

  logic                    in_acc;
  logic                    is_tick;
  logic signed [SMP_W-1:0] smp_x, smp_y;
  logic signed [SUM_W-1:0] sum_x_nx, sum_y_nx;
  logic [CNT_W-1:0]        cnt_nx;
  logic                    close;
  logic                    div_start, div_done;
  logic [AVG_W-1:0]        div_quo;
  logic [SUM_W-1:0]        div_dvd;
  logic                    out_free;
  logic signed [AVG_W-1:0] cls_x, cls_y;
  ev_e                     cls_ev;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = s_axis_tuser[0];
  assign smp_x         = s_axis_tdata[SMP_W-1:0];
  assign smp_y         = s_axis_tdata[2*SMP_W-1:SMP_W];

  // accumulate and test for window close
  assign sum_x_nx = sum_x_q + SUM_W'(smp_x);
  assign sum_y_nx = sum_y_q + SUM_W'(smp_y);
  assign cnt_nx   = cnt_q + 1'b1;
  assign close    = (ticks_q > window_q) || (cnt_nx >= CNT_W'(MAX_SAMPLES));

  // divider operand select: X pass, then Y pass
  assign div_start = (state_q == ST_X_GO) || (state_q == ST_Y_GO);
  always_comb begin
    if (state_q == ST_X_GO) begin
      div_dvd = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
    end else begin
      div_dvd = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
    end
  end

  twdc_divider #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (cnt_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  twdc_classify u_cls (
    .mag_x_i(qx_q),
    .mag_y_i(div_quo),
    .neg_x_i(sum_x_q[SUM_W-1]),
    .neg_y_i(sum_y_q[SUM_W-1]),
    .cfg_i  (cfg_q),
    .ev_i   (ev_q),
    .avg_x_o(cls_x),
    .avg_y_o(cls_y),
    .ev_o   (cls_ev)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer, window state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      cnt_q       <= '0;
      ticks_q     <= '0;
      ev_q        <= EV_NONE;
      qx_q        <= '0;
      out_valid_q <= 1'b0;
      out_ev_q    <= EV_NONE;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      // output valid: set on load, cleared once taken
      if (state_q == ST_LOAD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_tick) begin
              if (ticks_q != '1) ticks_q <= ticks_q + 1'b1;
            end else begin
              sum_x_q <= sum_x_nx;
              sum_y_q <= sum_y_nx;
              cnt_q   <= cnt_nx;
              if (close) state_q <= ST_X_GO;
            end
          end
        end
        ST_X_GO:   state_q <= ST_X_WAIT;
        ST_X_WAIT: begin
          if (div_done) begin
            qx_q    <= div_quo;
            state_q <= ST_Y_GO;
          end
        end
        ST_Y_GO:   state_q <= ST_Y_WAIT;
        ST_Y_WAIT: begin
          if (div_done) state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_ev_q    <= cls_ev;
            out_x_q     <= cls_x;
            out_y_q     <= cls_y;
            ev_q        <= cls_ev;
            sum_x_q     <= '0;
            sum_y_q     <= '0;
            cnt_q       <= '0;
            ticks_q     <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Y quotient stays on the divider output through ST_LOAD
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_y_q, out_x_q, out_ev_q};

endmodule : tilt_window_direction_classifier_core

`default_nettype wire

// File: src/twdc_divider.sv
// ----------------------------------------------------------------------------
// twdc_divider: shared serial divider
// Restoring division of a sum magnitude times 16 by the sample count,
// one quotient bit per cycle, AVG_W quotient bits per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twdc_divider #(
  parameter int unsigned MAX_SAMPLES = twdc_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              start_i,
  input  wire logic [$clog2(MAX_SAMPLES+1)+twdc_pkg::SMP_W-1:0] dividend_i,
  input  wire logic [$clog2(MAX_SAMPLES+1)-1:0]                  divisor_i,
  output logic                                                   done_o,
  output logic [twdc_pkg::AVG_W-1:0]                             quotient_o
);
  import twdc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = CNT_W + SMP_W;
  localparam int unsigned DVD_W  = SUM_W + Q4_SHIFT;
  localparam int unsigned STEP_W = $clog2(AVG_W);

  logic [DVD_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dsh_q, dsh_d;
  logic [AVG_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              fits;

  // one compare and subtract per cycle
  assign fits = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {dividend_i, {Q4_SHIFT{1'b0}}};
      dsh_d  = DVD_W'(divisor_i) << (AVG_W - 1);
      quo_d  = '0;
      step_d = STEP_W'(AVG_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[AVG_W-2:0], fits};
      dsh_d = dsh_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : twdc_divider

`default_nettype wire

// File: src/twdc_classify.sv
// ----------------------------------------------------------------------------
// twdc_classify: average forming and tilt classification
// Applies signs, saturation and the Y offset, then picks the direction
// with hysteresis between the change and release thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twdc_classify (
  input  wire logic [twdc_pkg::AVG_W-1:0] mag_x_i,
  input  wire logic [twdc_pkg::AVG_W-1:0] mag_y_i,
  input  wire logic                       neg_x_i,
  input  wire logic                       neg_y_i,
  input  wire twdc_pkg::cls_cfg_t         cfg_i,
  input  wire twdc_pkg::ev_e              ev_i,
  output logic signed [twdc_pkg::AVG_W-1:0] avg_x_o,
  output logic signed [twdc_pkg::AVG_W-1:0] avg_y_o,
  output twdc_pkg::ev_e                   ev_o
);
  import twdc_pkg::*;

  localparam int unsigned W1 = AVG_W + 1;
  localparam int unsigned W2 = AVG_W + 2;
  localparam logic signed [W2-1:0] SAT_HI = W2'((1 << (AVG_W - 1)) - 1);
  localparam logic signed [W2-1:0] SAT_LO = -W2'(1 << (AVG_W - 1));

  logic signed [W1-1:0]    sx, sy;
  logic signed [W2-1:0]    wx, wy;
  logic signed [AVG_W-1:0] ax, ay;
  logic [AVG_W-1:0]        mx, my;
  logic [AVG_W-1:0]        chg, rel;

  // signed averages, Y offset removed
  always_comb begin
    sx = neg_x_i ? -$signed({1'b0, mag_x_i}) : $signed({1'b0, mag_x_i});
    sy = neg_y_i ? -$signed({1'b0, mag_y_i}) : $signed({1'b0, mag_y_i});
    wx = W2'(sx);
    wy = W2'(sy) - W2'(cfg_i.y_offset);
  end

  // saturate to the output range
  always_comb begin
    if (wx > SAT_HI)      ax = SAT_HI[AVG_W-1:0];
    else if (wx < SAT_LO) ax = SAT_LO[AVG_W-1:0];
    else                  ax = wx[AVG_W-1:0];
    if (wy > SAT_HI)      ay = SAT_HI[AVG_W-1:0];
    else if (wy < SAT_LO) ay = SAT_LO[AVG_W-1:0];
    else                  ay = wy[AVG_W-1:0];
  end

  // magnitudes, full negative value fits unsigned
  assign mx  = ax[AVG_W-1] ? AVG_W'(-ax) : AVG_W'(ax);
  assign my  = ay[AVG_W-1] ? AVG_W'(-ay) : AVG_W'(ay);
  assign chg = AVG_W'(cfg_i.change_thr);
  assign rel = AVG_W'(cfg_i.release_thr);

  // hysteresis; ties go to the horizontal axis
  always_comb begin
    ev_o = ev_i;
    if (my > chg || mx > chg) begin
      if (my > mx) ev_o = ay[AVG_W-1] ? EV_UP : EV_DOWN;
      else         ev_o = ax[AVG_W-1] ? EV_LEFT : EV_RIGHT;
    end else if (my < rel && mx < rel) begin
      ev_o = EV_NONE;
    end
  end

  assign avg_x_o = ax;
  assign avg_y_o = ay;

endmodule : twdc_classify

`default_nettype wire

// File: src/twdc_checker.sv
// ----------------------------------------------------------------------------
// twdc_checker: port-level assertions for the classifier core
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twdc_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [0:0]                      s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [twdc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import twdc_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // a tick transaction never creates a result
  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser[0] && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result after a tick transaction");

  // a new result only appears after the input side was held off
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a division pass");

  // a sample after which the core stays ready gives no result
  a_sample_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tuser[0] && !m_axis_tvalid)
      ##1 s_axis_tready |-> !m_axis_tvalid)
    else $error("result without a busy phase");

endmodule : twdc_checker

bind tilt_window_direction_classifier_core twdc_checker u_twdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// File: verif/tilt_window_direction_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// tilt_window_direction_classifier_core_tb: self-checking bench of the classifier
// Streams tick and sample transactions into the core and predicts each window
// close: the Q4 averages, the Y offset with saturation and the tilt event with
// hysteresis. Every result transaction is checked field by field against the
// oldest predicted report. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_window_direction_classifier_core_tb;
  import twdc_pkg::*;

  localparam int          MAX_SMP     = DEF_MAX_SAMPLES;
  localparam int          AVG_MAX     = 2 ** (AVG_W - 1) - 1;
  localparam int          AVG_MIN     = -(2 ** (AVG_W - 1));
  localparam int          TICK_MAX    = 2 ** TICK_W - 1;
  localparam int          Q4_SCALE    = 1 << Q4_SHIFT;
  localparam int          DRAIN_WAIT  = 40;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // one window report as it leaves the core
  typedef struct {
    ev_e                     dir;
    logic signed [AVG_W-1:0] avg_x;
    logic signed [AVG_W-1:0] avg_y;
  } tilt_report_t;

  // window predictor and report checker
  class tilt_window_scoreboard;
    logic [THR_W-1:0]        change_thr;
    logic [THR_W-1:0]        release_thr;
    logic signed [AVG_W-1:0] y_offset;
    logic [TICK_W-1:0]       window;
    int                      max_samples;
    int                      sum_x;
    int                      sum_y;
    int                      count;
    int                      ticks;
    ev_e                     held_event;
    tilt_report_t            reports_due[$];
    int                      mismatches;
    int                      reports_seen;

    function new(int max_smp);
      change_thr   = RST_CHANGE_THR;
      release_thr  = RST_RELEASE_THR;
      y_offset     = RST_Y_OFFSET;
      window       = RST_WINDOW;
      max_samples  = max_smp;
      sum_x        = 0;
      sum_y        = 0;
      count        = 0;
      ticks        = 0;
      held_event   = EV_NONE;
      mismatches   = 0;
      reports_seen = 0;
    endfunction

    function int pending();
      return reports_due.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_CHANGE_THR:  change_thr  = value[THR_W-1:0];
        CFG_RELEASE_THR: release_thr = value[THR_W-1:0];
        CFG_Y_OFFSET:    y_offset    = value[AVG_W-1:0];
        CFG_WINDOW:      window      = value[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function int sat_q4(int v);
      if (v > AVG_MAX) return AVG_MAX;
      if (v < AVG_MIN) return AVG_MIN;
      return v;
    endfunction

    // hysteresis: strong tilt picks a direction, weak tilt releases to none
    function void classify(int qx, int qy);
      int mx;
      int my;
      mx = (qx < 0) ? -qx : qx;
      my = (qy < 0) ? -qy : qy;
      if (my > int'(change_thr) || mx > int'(change_thr)) begin
        if (my > mx) held_event = (qy < 0) ? EV_UP : EV_DOWN;
        else         held_event = (qx < 0) ? EV_LEFT : EV_RIGHT;
      end else if (my < int'(release_thr) && mx < int'(release_thr)) begin
        held_event = EV_NONE;
      end
    endfunction

    // accepted input transaction
    function void note_item(bit action, logic signed [SMP_W-1:0] x,
                            logic signed [SMP_W-1:0] y);
      int qx;
      int qy;
      tilt_report_t rep;
      if (action) begin
        if (ticks < TICK_MAX) ticks++;
        return;
      end
      count++;
      sum_x += x;
      sum_y += y;
      if (!(ticks > int'(window) || count >= max_samples)) return;
      // Q4 averages truncate toward zero
      qx = sat_q4((sum_x * Q4_SCALE) / count);
      qy = sat_q4((sum_y * Q4_SCALE) / count - int'(y_offset));
      classify(qx, qy);
      rep.dir   = held_event;
      rep.avg_x = AVG_W'(qx);
      rep.avg_y = AVG_W'(qy);
      reports_due.push_back(rep);
      sum_x = 0;
      sum_y = 0;
      count = 0;
      ticks = 0;
    endfunction

    // accepted result transaction
    function void check_report(logic [OUT_DATA_W-1:0] word);
      tilt_report_t            want;
      logic [EV_W-1:0]         got_dir;
      logic signed [AVG_W-1:0] got_x;
      logic signed [AVG_W-1:0] got_y;
      got_dir = word[EV_W-1:0];
      got_x   = word[EV_W +: AVG_W];
      got_y   = word[EV_W+AVG_W +: AVG_W];
      reports_seen++;
      if (reports_due.size() == 0) begin
        $error("result with no window closed: tdata %h", word);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      if (got_dir !== want.dir) begin
        $error("direction_event: expected %0d, got %0d", want.dir, got_dir);
        mismatches++;
      end
      if (got_x !== want.avg_x) begin
        $error("average_x: expected %0d, got %0d", want.avg_x, got_x);
        mismatches++;
      end
      if (got_y !== want.avg_y) begin
        $error("average_y: expected %0d, got %0d", want.avg_y, got_y);
        mismatches++;
      end
      if (word[OUT_DATA_W-1:EV_W+2*AVG_W] !== '0) begin
        $error("tdata padding: expected 0, got %0h", word[OUT_DATA_W-1:EV_W+2*AVG_W]);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // sample_x, sample_y
  logic [0:0]            s_axis_tuser;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // event, avg_x, avg_y
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tilt_window_scoreboard sb;
  bit                    tx_idle = 1'b1;
  bit                    rx_idle = 1'b1;
  int                    items_sent = 0;
  int unsigned           cycles = 0;

  tilt_window_direction_classifier_core #(
    .MAX_SAMPLES(MAX_SMP)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
  end

  // result sink with random stalls
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid));
    end
  end

  // one input transaction, after a random gap
  task automatic send_item(bit action, logic [SMP_W-1:0] x, logic [SMP_W-1:0] y);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= action;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(action, x, y);
    items_sent++;
  endtask

  task automatic push_tick();
    send_item(1'b1, SMP_W'($urandom), SMP_W'($urandom));
  endtask

  task automatic push_sample(int x, int y);
    send_item(1'b0, SMP_W'(x), SMP_W'(y));
  endtask

  // hold the sender until every report is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  task automatic settle();
    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    sb.set_reg(idx, CFG_DATA_W'(value));
  endtask

  task automatic apply_settings(int chg, int rel, int off, int win);
    write_reg(CFG_CHANGE_THR, chg);
    write_reg(CFG_RELEASE_THR, rel);
    write_reg(CFG_Y_OFFSET, off);
    write_reg(CFG_WINDOW, win);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int clamp_smp(int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v;
  endfunction

  // ticks then a burst of samples around a random tilt
  task automatic random_window(int win);
    int n_ticks;
    int n_smp;
    int bx;
    int by;
    n_ticks = $urandom_range(0, win + 2);
    n_smp   = $urandom_range(1, 6);
    bx      = $urandom_range(0, 255) - 128;
    by      = $urandom_range(0, 255) - 128;
    repeat (n_ticks) push_tick();
    repeat (n_smp) begin
      if ($urandom_range(0, 3) == 0)
        push_sample($urandom_range(0, 255), $urandom_range(0, 255));
      else
        push_sample(clamp_smp(bx + $urandom_range(0, 16) - 8),
                    clamp_smp(by + $urandom_range(0, 16) - 8));
    end
  endtask

  initial begin
    int start_items;
    int start_reports;
    int phase;
    int chg;
    int rel;
    int off;
    int win;
    sb = new(MAX_SMP);
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_CHANGE_THR;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset register values: a window needs more than 100 ticks
    push_sample(127, -128);
    repeat (101) push_tick();
    push_sample(127, 127);
    repeat (101) push_tick();
    push_sample(-128, -128);

    // zero-tick window: no close before the first tick, then directions
    settle();
    apply_settings(50, 20, 0, 0);
    push_sample(0, 0);
    push_tick();
    push_sample(127, 127);       // equal magnitudes go horizontal
    push_tick();
    push_sample(-128, 0);
    push_tick();
    push_sample(0, -128);
    push_tick();
    push_sample(0, 127);
    push_tick();
    push_sample(1, 1);           // below release
    push_tick();
    push_sample(127, 0);
    push_tick();
    push_sample(2, 1);           // between thresholds, event held
    push_tick();
    push_tick();
    push_sample(-1, 0);
    push_sample(1, -1);          // averages truncate toward zero
    push_sample(0, 0);
    push_tick();
    push_sample(0, 0);

    // offset overflow in both directions, threshold extremes
    settle();
    apply_settings(0, 2047, -2048, 0);
    push_tick();
    push_sample(127, 127);
    push_tick();
    push_sample(0, 0);
    settle();
    apply_settings(2047, 0, 2047, 1);
    push_tick();
    push_sample(-128, -128);
    push_tick();
    push_sample(-128, -128);
    push_tick();
    push_tick();
    push_sample(0, 0);

    // random phases, each with its own settings
    start_items   = items_sent;
    start_reports = sb.reports_seen;
    phase         = 0;
    while (items_sent - start_items < 260 || sb.reports_seen - start_reports < 40) begin
      chg = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 0 : 2047)
                                        : $urandom_range(0, 800);
      rel = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 0 : 2047)
                                        : $urandom_range(0, chg);
      off = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? -2048 : 2047)
                                        : $urandom_range(0, 400) - 200;
      win = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      settle();
      apply_settings(chg, rel, off, win);
      tx_idle = (phase % 3 != 2);
      rx_idle = (phase % 4 != 3);
      for (int w = 0; w < 12; w++) begin
        if (w == 6) drain();
        if ($urandom_range(0, 7) == 0) begin
          // noise: loose ticks and samples
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) push_tick();
            else push_sample($urandom_range(0, 255), $urandom_range(0, 255));
          end
        end else begin
          random_window(win);
        end
      end
      phase++;
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
